// ----- rtl/pdc_pkg.sv -----
// ----------------------------------------------------------------------------
// pdc_pkg
// Shared types, codes and helpers for the pairwise difference counter.
// ----------------------------------------------------------------------------
`default_nettype none

package pdc_pkg;

  localparam int MAX_SAMPLES = 32;
  localparam int COUNT_WIDTH = 16;
  localparam int SAMPLE_W    = 5;
  localparam int NSAMP_W     = 6;
  localparam int ROW_W       = 2 * MAX_SAMPLES;
  localparam int DIFF_W      = 16;
  localparam int PADDR_W     = 3;
  localparam int PDATA_W     = 32;

  localparam logic [COUNT_WIDTH-1:0] COUNT_MAX = {COUNT_WIDTH{1'b1}};

  // command codes
  localparam logic [1:0] CMD_CLEAR = 2'd0;
  localparam logic [1:0] CMD_ADD   = 2'd1;
  localparam logic [1:0] CMD_READ  = 2'd2;

  // status codes
  localparam logic ST_OK       = 1'b0;
  localparam logic ST_BAD_PAIR = 1'b1;

  // register index, taken from paddr[2]
  localparam logic REG_NUM_SAMPLES = 1'b0;
  localparam logic REG_PLOIDY      = 1'b1;

  localparam logic [NSAMP_W-1:0] NUM_SAMPLES_RST = NSAMP_W'(MAX_SAMPLES);
  localparam logic               PLOIDY_RST      = 1'b0;

  typedef struct packed {
    logic [1:0]          cmd;
    logic [ROW_W-1:0]    genotype_row;
    logic [SAMPLE_W-1:0] sample_a;
    logic [SAMPLE_W-1:0] sample_b;
  } pdc_req_t;

  typedef struct packed {
    logic [DIFF_W-1:0] diff_count;
    logic              status;
  } pdc_res_t;

  // broadcast to every lane on an accepted request
  typedef struct packed {
    logic                          clear;
    logic                          add;
    logic                          rd;
    logic [MAX_SAMPLES-1:0]        live;   // code valid and sample in use
    logic [MAX_SAMPLES-1:0][1:0]   codes;
    logic [SAMPLE_W-1:0]           sample_b;
  } pdc_lane_ctl_t;

  // request waiting for the merge stage
  typedef struct packed {
    logic                rd;
    logic                bad;
    logic [SAMPLE_W-1:0] sample_a;
  } pdc_stage_t;

  function automatic logic code_ok(input logic [1:0] code, input logic diploid);
    code_ok = diploid ? (code <= 2'd2) : (code <= 2'd1);
  endfunction

  // a counter wider than the result field reads as all ones when over range
  function automatic logic [DIFF_W-1:0] clamp_count(input logic [COUNT_WIDTH-1:0] v);
    logic [31:0] wide;
    wide = 32'(v);
    clamp_count = (wide > 32'h0000_FFFF) ? {DIFF_W{1'b1}} : wide[DIFF_W-1:0];
  endfunction

endpackage

`default_nettype wire

// ----- rtl/pdc_lane.sv -----
// ----------------------------------------------------------------------------
// pdc_lane
// One lane per first sample: the counters of pairs (lane_id, b), b > lane_id.
// ----------------------------------------------------------------------------
`default_nettype none

module pdc_lane (
  input  wire logic                             clk,
  input  wire logic                             rst,
  input  wire logic [pdc_pkg::SAMPLE_W-1:0]     lane_id,
  input  wire pdc_pkg::pdc_lane_ctl_t           ctl,
  output logic      [pdc_pkg::COUNT_WIDTH-1:0]  rd_count
);
  import pdc_pkg::*;

  logic [COUNT_WIDTH-1:0] cnt [MAX_SAMPLES];
  logic [1:0]             code_a;
  logic                   live_a;

  assign code_a = ctl.codes[lane_id];
  assign live_a = ctl.live[lane_id];

  for (genvar b = 0; b < MAX_SAMPLES; b++) begin : g_cnt
    logic inc;
    assign inc = ctl.add && live_a && ctl.live[b] && (ctl.codes[b] != code_a) &&
                 (SAMPLE_W'(b) > lane_id);

    always_ff @(posedge clk) begin
      if (rst) begin
        cnt[b] <= '0;
      end else if (ctl.clear) begin
        cnt[b] <= '0;
      end else if (inc && (cnt[b] != COUNT_MAX)) begin
        cnt[b] <= cnt[b] + COUNT_WIDTH'(1);
      end
    end
  end

  // snapshot for the merge stage
  always_ff @(posedge clk) begin
    if (ctl.rd) begin
      rd_count <= cnt[ctl.sample_b];
    end
  end

  for (genvar b = 0; b < MAX_SAMPLES; b++) begin : g_chk
    a_clear_zero: assert property (@(posedge clk) disable iff (rst)
      ctl.clear |=> (cnt[b] == '0))
      else $error("counter not cleared");
    a_sat_hold: assert property (@(posedge clk) disable iff (rst)
      (cnt[b] == COUNT_MAX) && !ctl.clear |=> (cnt[b] == COUNT_MAX))
      else $error("saturated counter moved");
  end

endmodule

`default_nettype wire

// ----- rtl/pdc_merge.sv -----
// ----------------------------------------------------------------------------
// pdc_merge
// Picks the lane of the first sample, clamps, and holds the result register.
// ----------------------------------------------------------------------------
`default_nettype none

module pdc_merge (
  input  wire logic                                                 clk,
  input  wire logic                                                 rst,
  input  wire logic                                                 s1_valid,
  input  wire pdc_pkg::pdc_stage_t                                  s1,
  input  wire logic [pdc_pkg::MAX_SAMPLES-1:0][pdc_pkg::COUNT_WIDTH-1:0] lane_rd,
  output logic                                                      s1_move,
  output logic                                                      res_valid,
  input  wire logic                                                 res_ready,
  output pdc_pkg::pdc_res_t                                         res_data
);
  import pdc_pkg::*;

  pdc_res_t res_next;

  assign s1_move = !res_valid || res_ready;

  always_comb begin
    res_next.diff_count = '0;
    res_next.status     = ST_OK;
    if (s1.rd) begin
      if (s1.bad) begin
        res_next.status = ST_BAD_PAIR;
      end else begin
        res_next.diff_count = clamp_count(lane_rd[s1.sample_a]);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      res_valid <= 1'b0;
    end else if (s1_valid && s1_move) begin
      res_valid <= 1'b1;
    end else if (res_ready) begin
      res_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_valid && s1_move) begin
      res_data <= res_next;
    end
  end

  a_bad_zero: assert property (@(posedge clk) disable iff (rst)
    res_valid && (res_data.status == ST_BAD_PAIR) |-> (res_data.diff_count == '0))
    else $error("bad pair with non-zero count");
  a_advance: assert property (@(posedge clk) disable iff (rst)
    s1_valid && s1_move |=> res_valid)
    else $error("result lost on advance");

endmodule

`default_nettype wire

// ----- rtl/pairwise_difference_counter.sv -----
// ----------------------------------------------------------------------------
// pairwise_difference_counter
// Saturating difference counts for every pair of samples over genotype rows.
// ----------------------------------------------------------------------------
// One request per cycle while the result side takes its results: clear, add
// and read each give exactly one result. The lane snapshot and the middle
// stage load at the accepting edge, and the result register loads from them
// when the middle stage moves on to the result. The
// counters sit in 32 lanes of flip-flops, one lane per first sample, and an
// add updates all 496 pair counters at the edge the request is accepted, so
// a read directly behind an add already sees it. A read picks the second
// sample in each lane into a snapshot register; the merge stage then picks
// the lane of the first sample and clamps to the 16-bit result. Counters
// come out of reset at zero with no clearing pass. Back-pressure on the
// result side holds the single middle stage; req_ready drops only when both
// the middle stage and the result register are full and the result is not
// taken.
// Configuration (APB, pready always high): 0x0 num_samples, 0x4 ploidy_mode.
// ----------------------------------------------------------------------------
`default_nettype none

module pairwise_difference_counter (
  input  wire logic                           clk,
  input  wire logic                           rst,
  // request channel
  input  wire logic                           req_valid,
  output logic                                req_ready,
  input  wire pdc_pkg::pdc_req_t              req_data,
  // result channel
  output logic                                res_valid,
  input  wire logic                           res_ready,
  output pdc_pkg::pdc_res_t                   res_data,
  // configuration
  input  wire logic                           psel,
  input  wire logic                           penable,
  input  wire logic                           pwrite,
  input  wire logic [pdc_pkg::PADDR_W-1:0]    paddr,
  input  wire logic [pdc_pkg::PDATA_W-1:0]    pwdata,
  output logic      [pdc_pkg::PDATA_W-1:0]    prdata,
  output logic                                pready
);
  import pdc_pkg::*;

  logic [NSAMP_W-1:0] num_samples;
  logic               ploidy_mode;

  logic               req_acc;
  pdc_lane_ctl_t      ctl;

  logic               s1_valid;
  pdc_stage_t         s1;
  pdc_stage_t         s1_next;
  logic               s1_move;

  logic [MAX_SAMPLES-1:0][COUNT_WIDTH-1:0] lane_rd;

  // --- configuration registers ---------------------------------------------
  assign pready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      num_samples <= NUM_SAMPLES_RST;
      ploidy_mode <= PLOIDY_RST;
    end else if (psel && penable && pwrite) begin
      case (paddr[2])
        REG_NUM_SAMPLES: num_samples <= pwdata[NSAMP_W-1:0];
        REG_PLOIDY:      ploidy_mode <= pwdata[0];
        default:         ;
      endcase
    end
  end

  always_comb begin
    case (paddr[2])
      REG_NUM_SAMPLES: prdata = PDATA_W'(num_samples);
      REG_PLOIDY:      prdata = PDATA_W'(ploidy_mode);
      default:         prdata = '0;
    endcase
  end

  // --- request decode, broadcast to the lanes ------------------------------
  // The middle stage takes a request when it is empty or moving on to the result.
  assign req_ready = !s1_valid || s1_move;
  assign req_acc   = req_valid && req_ready;

  always_comb begin
    ctl.clear    = req_acc && (req_data.cmd == CMD_CLEAR);
    ctl.add      = req_acc && (req_data.cmd == CMD_ADD);
    ctl.rd       = req_acc && (req_data.cmd == CMD_READ);
    ctl.sample_b = req_data.sample_b;
    for (int n = 0; n < MAX_SAMPLES; n++) begin
      ctl.codes[n] = req_data.genotype_row[2*n +: 2];
      // n below num_samples also covers counts above the lane count
      ctl.live[n]  = code_ok(req_data.genotype_row[2*n +: 2], ploidy_mode) &&
                     (NSAMP_W'(n) < num_samples);
    end
  end

  // pair check for reads: a below b, b in use
  always_comb begin
    s1_next.rd       = (req_data.cmd == CMD_READ);
    s1_next.bad      = !((req_data.sample_a < req_data.sample_b) &&
                         (NSAMP_W'(req_data.sample_b) < num_samples));
    s1_next.sample_a = req_data.sample_a;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (req_acc) begin
      s1_valid <= 1'b1;
    end else if (s1_move) begin
      s1_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (req_acc) begin
      s1 <= s1_next;
    end
  end

  // --- lanes -----------------------------------------------------------------
  for (genvar a = 0; a < MAX_SAMPLES; a++) begin : g_lane
    pdc_lane u_lane (
      .clk      (clk),
      .rst      (rst),
      .lane_id  (SAMPLE_W'(a)),
      .ctl      (ctl),
      .rd_count (lane_rd[a])
    );
  end

  // --- merge and result register ---------------------------------------------
  pdc_merge u_merge (
    .clk       (clk),
    .rst       (rst),
    .s1_valid  (s1_valid),
    .s1        (s1),
    .lane_rd   (lane_rd),
    .s1_move   (s1_move),
    .res_valid (res_valid),
    .res_ready (res_ready),
    .res_data  (res_data)
  );

  a_stage_hold: assert property (@(posedge clk) disable iff (rst)
    s1_valid && !s1_move |=> s1_valid && $stable(s1))
    else $error("middle stage dropped a request");

endmodule

`default_nettype wire
